FILE: rtl/ccp_pkg.sv
// Shared types, constants and arithmetic helpers for the current offset Clarke/Park block.
`timescale 1ns / 1ps
package ccp_pkg;

  // Calibration length and trig precision
  localparam int CALIB_SAMPLES  = 10;
  localparam int TRIG_FRAC_BITS = 15;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_CURRENT_GAIN = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_POLE_PAIRS   = 1'b1;
  localparam logic [15:0] GAIN_RESET = 16'd288;
  localparam logic [3:0]  POLE_PAIRS_RESET = 4'd2;

  // Calibration count limit
  localparam logic [6:0] CALIB_LAST = 7'(CALIB_SAMPLES);

  // Offset division by reciprocal multiply: exact for every 18-bit sum
  localparam int DIV_SHIFT = 25;
  localparam logic [25:0] DIV_RECIP =
    26'(((64'd1 << DIV_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

  // Electrical angle mod 360 by reciprocal multiply: exact below 2^13
  localparam int EANG_SHIFT = 22;
  localparam logic [13:0] EANG_RECIP = 14'(((64'd1 << EANG_SHIFT) + 64'd359) / 64'd360);

  // Q16 to Q_F conversion
  localparam int QF_SHIFT = 16 - TRIG_FRAC_BITS;
  localparam logic [17:0] QF_HALF = (QF_SHIFT == 0) ? 18'd0 : 18'(18'd1 << (QF_SHIFT - 1));
  localparam logic [17:0] INV_SQRT3_Q16 = 18'd37837;
  localparam logic signed [17:0] INV_SQRT3_K =
    $signed(18'((INV_SQRT3_Q16 + QF_HALF) >> QF_SHIFT));

  // Rounding constant for products in Q_F
  localparam logic signed [33:0] TRIG_HALF = 34'sd1 <<< (TRIG_FRAC_BITS - 1);

  // Output saturation limits
  localparam logic signed [33:0] OUT_MIN = -34'sd16384;
  localparam logic signed [33:0] OUT_MAX = 34'sd16383;

  typedef logic [11:0]        ccp_sample_t;
  typedef logic signed [14:0] ccp_cur_t;
  typedef logic [8:0]         ccp_angle_t;
  typedef logic signed [17:0] ccp_trig_t;

  // Datapath step enables issued by the controller
  typedef struct packed {
    logic cap;
    logic acc;
    logic div_mul;
    logic div_set;
    logic cur;
    logic scl;
    logic bet;
    logic ang;
    logic trig;
    logic park;
    logic load;
  } ccp_cmd_t;

  // Saturate to the 15-bit output range
  function automatic ccp_cur_t sat15(input logic signed [33:0] v);
    ccp_cur_t r;
    if (v < OUT_MIN) begin
      r = 15'(OUT_MIN);
    end else if (v > OUT_MAX) begin
      r = 15'(OUT_MAX);
    end else begin
      r = 15'(v);
    end
    return r;
  endfunction

  // Quarter-wave sine in Q16, whole degrees 0..90
  function automatic logic [16:0] sine_q16(input logic [6:0] k);
    logic [16:0] v;
    case (k)
      7'd0: v = 17'd0;         7'd1: v = 17'd1144;      7'd2: v = 17'd2287;
      7'd3: v = 17'd3430;      7'd4: v = 17'd4572;      7'd5: v = 17'd5712;
      7'd6: v = 17'd6850;      7'd7: v = 17'd7987;      7'd8: v = 17'd9121;
      7'd9: v = 17'd10252;     7'd10: v = 17'd11380;    7'd11: v = 17'd12505;
      7'd12: v = 17'd13626;    7'd13: v = 17'd14742;    7'd14: v = 17'd15855;
      7'd15: v = 17'd16962;    7'd16: v = 17'd18064;    7'd17: v = 17'd19161;
      7'd18: v = 17'd20252;    7'd19: v = 17'd21336;    7'd20: v = 17'd22415;
      7'd21: v = 17'd23486;    7'd22: v = 17'd24550;    7'd23: v = 17'd25607;
      7'd24: v = 17'd26656;    7'd25: v = 17'd27697;    7'd26: v = 17'd28729;
      7'd27: v = 17'd29753;    7'd28: v = 17'd30767;    7'd29: v = 17'd31772;
      7'd30: v = 17'd32768;    7'd31: v = 17'd33754;    7'd32: v = 17'd34729;
      7'd33: v = 17'd35693;    7'd34: v = 17'd36647;    7'd35: v = 17'd37590;
      7'd36: v = 17'd38521;    7'd37: v = 17'd39441;    7'd38: v = 17'd40348;
      7'd39: v = 17'd41243;    7'd40: v = 17'd42126;    7'd41: v = 17'd42995;
      7'd42: v = 17'd43852;    7'd43: v = 17'd44695;    7'd44: v = 17'd45525;
      7'd45: v = 17'd46341;    7'd46: v = 17'd47143;    7'd47: v = 17'd47930;
      7'd48: v = 17'd48703;    7'd49: v = 17'd49461;    7'd50: v = 17'd50203;
      7'd51: v = 17'd50931;    7'd52: v = 17'd51643;    7'd53: v = 17'd52339;
      7'd54: v = 17'd53020;    7'd55: v = 17'd53684;    7'd56: v = 17'd54332;
      7'd57: v = 17'd54963;    7'd58: v = 17'd55578;    7'd59: v = 17'd56175;
      7'd60: v = 17'd56756;    7'd61: v = 17'd57319;    7'd62: v = 17'd57865;
      7'd63: v = 17'd58393;    7'd64: v = 17'd58903;    7'd65: v = 17'd59396;
      7'd66: v = 17'd59870;    7'd67: v = 17'd60326;    7'd68: v = 17'd60764;
      7'd69: v = 17'd61183;    7'd70: v = 17'd61584;    7'd71: v = 17'd61966;
      7'd72: v = 17'd62328;    7'd73: v = 17'd62672;    7'd74: v = 17'd62997;
      7'd75: v = 17'd63303;    7'd76: v = 17'd63589;    7'd77: v = 17'd63856;
      7'd78: v = 17'd64104;    7'd79: v = 17'd64332;    7'd80: v = 17'd64540;
      7'd81: v = 17'd64729;    7'd82: v = 17'd64898;    7'd83: v = 17'd65048;
      7'd84: v = 17'd65177;    7'd85: v = 17'd65287;    7'd86: v = 17'd65376;
      7'd87: v = 17'd65446;    7'd88: v = 17'd65496;    7'd89: v = 17'd65526;
      7'd90: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // Full-circle sine in Q_F for an angle of 0..359 degrees
  function automatic ccp_trig_t sine_deg(input logic [8:0] t);
    logic [6:0]  idx;
    logic        neg;
    logic [17:0] mag;
    if (t <= 9'd90) begin
      idx = 7'(t);
      neg = 1'b0;
    end else if (t <= 9'd180) begin
      idx = 7'(9'd180 - t);
      neg = 1'b0;
    end else if (t <= 9'd270) begin
      idx = 7'(t - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - t);
      neg = 1'b1;
    end
    mag = (18'(sine_q16(idx)) + QF_HALF) >> QF_SHIFT;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

FILE: rtl/ccp_in_if.sv
// ADC set channel: three phase samples and a rotor angle sample.
`timescale 1ns / 1ps
interface ccp_in_if;
  import ccp_pkg::*;

  logic        valid;
  logic        ready;
  ccp_sample_t sample_a;
  ccp_sample_t sample_b;
  ccp_sample_t sample_c;
  ccp_sample_t angle_sample;

  modport source (output valid, output sample_a, output sample_b, output sample_c,
                  output angle_sample, input ready);
  modport sink   (input valid, input sample_a, input sample_b, input sample_c,
                  input angle_sample, output ready);
endinterface

FILE: rtl/ccp_out_if.sv
// Result channel: corrected phase C current, Clarke and Park currents, electrical angle.
`timescale 1ns / 1ps
interface ccp_out_if;
  import ccp_pkg::*;

  logic       valid;
  logic       ready;
  ccp_cur_t   current_c;
  ccp_cur_t   current_alpha;
  ccp_cur_t   current_beta;
  ccp_cur_t   current_d;
  ccp_cur_t   current_q;
  ccp_angle_t electrical_angle;

  modport source (output valid, output current_c, output current_alpha,
                  output current_beta, output current_d, output current_q,
                  output electrical_angle, input ready);
  modport sink   (input valid, input current_c, input current_alpha,
                  input current_beta, input current_d, input current_q,
                  input electrical_angle, output ready);
endinterface

FILE: rtl/ccp_ctrl.sv
// Sequencer: calibration count, step enables and the handshake of both channels.
`timescale 1ns / 1ps
module ccp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ccp_pkg::ccp_cmd_t cmd,
  output logic              calibrated
);
  import ccp_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_DIV_MUL = 10'b0000000010,
    ST_DIV_SET = 10'b0000000100,
    ST_CUR     = 10'b0000001000,
    ST_SCL     = 10'b0000010000,
    ST_BET     = 10'b0000100000,
    ST_ANG     = 10'b0001000000,
    ST_TRIG    = 10'b0010000000,
    ST_PARK    = 10'b0100000000,
    ST_OUT     = 10'b1000000000
  } ccp_state_t;

  ccp_state_t state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       cal_r, cal_nxt;
  logic       oval_r, oval_nxt;
  logic       accept;
  logic [6:0] cnt_inc;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_valid  = oval_r;
  assign calibrated = cal_r;
  assign cnt_inc    = cnt_r + 7'd1;

  // Next state, calibration count and step enables
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cal_nxt   = cal_r;
    cmd       = '0;
    cmd.cap   = accept;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cal_r) begin
            state_nxt = ST_CUR;
          end else begin
            cmd.acc = 1'b1;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= CALIB_LAST) begin
              state_nxt = ST_DIV_MUL;
            end
          end
        end
      end
      ST_DIV_MUL: begin
        cmd.div_mul = 1'b1;
        state_nxt   = ST_DIV_SET;
      end
      ST_DIV_SET: begin
        cmd.div_set = 1'b1;
        cal_nxt     = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_CUR: begin
        cmd.cur   = 1'b1;
        state_nxt = ST_SCL;
      end
      ST_SCL: begin
        cmd.scl   = 1'b1;
        state_nxt = ST_BET;
      end
      ST_BET: begin
        cmd.bet   = 1'b1;
        state_nxt = ST_ANG;
      end
      ST_ANG: begin
        cmd.ang   = 1'b1;
        state_nxt = ST_TRIG;
      end
      ST_TRIG: begin
        cmd.trig  = 1'b1;
        state_nxt = ST_PARK;
      end
      ST_PARK: begin
        cmd.park  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (!oval_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop once the transaction completes
  always_comb begin
    if (cmd.load) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      cal_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cal_r   <= cal_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

FILE: rtl/ccp_datapath.sv
// Datapath: offset accumulation and division, scaling, Clarke, angle, sine lookup, Park.
`timescale 1ns / 1ps
module ccp_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ccp_pkg::ccp_cmd_t                     cmd,
  input  logic                                  cfg_we,
  input  logic [ccp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [ccp_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  ccp_pkg::ccp_sample_t                  sample_a,
  input  ccp_pkg::ccp_sample_t                  sample_b,
  input  ccp_pkg::ccp_sample_t                  sample_c,
  input  ccp_pkg::ccp_sample_t                  angle_sample,
  output ccp_pkg::ccp_cur_t                     current_c,
  output ccp_pkg::ccp_cur_t                     current_alpha,
  output ccp_pkg::ccp_cur_t                     current_beta,
  output ccp_pkg::ccp_cur_t                     current_d,
  output ccp_pkg::ccp_cur_t                     current_q,
  output ccp_pkg::ccp_angle_t                   electrical_angle
);
  import ccp_pkg::*;

  // Configuration
  logic [15:0] gain_r;
  logic [3:0]  pp_r;

  // Captured set
  ccp_sample_t smp_r [3];
  ccp_sample_t ang_r;

  // Calibration
  logic [17:0] sum_r  [3];
  logic [43:0] divp_r [3];
  logic [11:0] offs_r [3];

  // Current path
  logic signed [29:0] cprod_r [3];
  logic signed [12:0] diff    [3];
  logic signed [29:0] crnd    [3];
  ccp_cur_t           icur_r  [3];
  logic signed [16:0] bsum;
  logic signed [33:0] bprod_r;
  ccp_cur_t           beta_r;

  // Angle path
  logic [20:0] ang_mul;
  logic [8:0]  mech_r;
  logic [12:0] ep_r;
  logic [26:0] elq_r;
  logic [12:0] elsub;
  ccp_angle_t  el_r;
  logic [9:0]  cos_t;
  logic [8:0]  cos_idx;
  ccp_trig_t   sin_r, cos_r;

  // Park products
  logic signed [33:0] pd1_r, pd2_r, pq1_r, pq2_r;
  logic signed [33:0] dsum, qsum;

  // Result register
  ccp_cur_t   oc_r, oa_r, ob_r, od_r, oq_r;
  ccp_angle_t oe_r;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      pp_r   <= POLE_PAIRS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CURRENT_GAIN: gain_r <= cfg_wdata[15:0];
        CFG_POLE_PAIRS:   pp_r   <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the accepted set
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      smp_r[0] <= sample_a;
      smp_r[1] <= sample_b;
      smp_r[2] <= sample_c;
      ang_r    <= angle_sample;
    end
  end

  // Accumulate calibration sums and latch offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i]  <= '0;
        offs_r[i] <= '0;
      end
    end else begin
      if (cmd.acc) begin
        sum_r[0] <= sum_r[0] + 18'(sample_a);
        sum_r[1] <= sum_r[1] + 18'(sample_b);
        sum_r[2] <= sum_r[2] + 18'(sample_c);
      end
      if (cmd.div_set) begin
        for (int i = 0; i < 3; i++) begin
          offs_r[i] <= divp_r[i][DIV_SHIFT +: 12];
        end
      end
    end
  end

  // Offset division: multiply by the reciprocal of the sample count
  always_ff @(posedge clk) begin
    if (cmd.div_mul) begin
      for (int i = 0; i < 3; i++) begin
        divp_r[i] <= 44'(sum_r[i]) * 44'(DIV_RECIP);
      end
    end
  end

  // Offset-corrected differences and their rounding
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({1'b0, smp_r[i]}) - $signed({1'b0, offs_r[i]});
      crnd[i] = (cprod_r[i] + 30'sd128) >>> 8;
    end
  end

  assign ang_mul = 21'(ang_r) * 21'd360;
  assign bsum    = 17'(icur_r[0]) + (17'(icur_r[1]) <<< 1);
  assign elsub   = ep_r - 13'(elq_r[EANG_SHIFT +: 5]) * 13'd360;
  assign cos_t   = 10'(el_r) + 10'd90;
  assign cos_idx = (cos_t >= 10'd360) ? 9'(cos_t - 10'd360) : 9'(cos_t);
  assign dsum    = pd1_r + pd2_r + TRIG_HALF;
  assign qsum    = pq1_r - pq2_r + TRIG_HALF;

  // Step through the transform, one registered stage per command
  always_ff @(posedge clk) begin
    if (cmd.cur) begin
      for (int i = 0; i < 3; i++) begin
        cprod_r[i] <= 30'(diff[i]) * 30'($signed({1'b0, gain_r}));
      end
      mech_r <= ang_mul[20:12];
    end
    if (cmd.scl) begin
      for (int i = 0; i < 3; i++) begin
        icur_r[i] <= sat15(34'(crnd[i]));
      end
      ep_r <= 13'(mech_r) * 13'(pp_r);
    end
    if (cmd.bet) begin
      bprod_r <= 34'(bsum) * 34'(INV_SQRT3_K);
      elq_r   <= 27'(ep_r) * 27'(EANG_RECIP);
    end
    if (cmd.ang) begin
      beta_r <= sat15((bprod_r + TRIG_HALF) >>> TRIG_FRAC_BITS);
      el_r   <= elsub[8:0];
    end
    if (cmd.trig) begin
      sin_r <= sine_deg(el_r);
      cos_r <= sine_deg(cos_idx);
    end
    if (cmd.park) begin
      pd1_r <= 34'(icur_r[0]) * 34'(cos_r);
      pd2_r <= 34'(beta_r) * 34'(sin_r);
      pq1_r <= 34'(beta_r) * 34'(cos_r);
      pq2_r <= 34'(icur_r[0]) * 34'(sin_r);
    end
    if (cmd.load) begin
      oc_r <= icur_r[2];
      oa_r <= icur_r[0];
      ob_r <= beta_r;
      od_r <= sat15(dsum >>> TRIG_FRAC_BITS);
      oq_r <= sat15(qsum >>> TRIG_FRAC_BITS);
      oe_r <= el_r;
    end
  end

  assign current_c        = oc_r;
  assign current_alpha    = oa_r;
  assign current_beta     = ob_r;
  assign current_d        = od_r;
  assign current_q        = oq_r;
  assign electrical_angle = oe_r;

endmodule

FILE: rtl/current_offset_clarke_park.sv
// Top level: phase current offset calibration followed by Clarke and Park transforms.
//
// in_ch carries one ADC set per transaction (three phase samples, rotor angle).
// out_ch carries one result per set once calibration is done: phase C current,
// alpha, beta, d, q in Q8 amps and the electrical angle in whole degrees.
// cfg_we/cfg_addr/cfg_wdata write current_gain (index 0) and pole_pairs (1).
//
// The first CALIB_SAMPLES sets give no result. After the last of them the
// sequencer divides out the offsets (ST_DIV_MUL, ST_DIV_SET) before it takes a set.
// After calibration in_ch.ready stays low through the 7 sequencer steps that follow
// the transaction, one for each registered stage of the datapath
// (current product, scale, Clarke, angle reduction, sine lookup, Park products,
// output), so the next transaction comes after them at the earliest.
// out_ch.valid rises once the output step has loaded the result register.
// The result sits in an output register, so a new set is taken while it waits;
// if the receiver still stalls when the next result is ready, the sequencer
// holds in its last step until out_ch.ready frees the register.
// Reset (rst_n low, synchronous) clears the sums, offsets, calibration count,
// sets current_gain to 288 and pole_pairs to 2, and drops out_ch.valid.
`timescale 1ns / 1ps
module current_offset_clarke_park (
  input  logic                           clk,
  input  logic                           rst_n,
  ccp_in_if.sink                         in_ch,
  ccp_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ccp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ccp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ccp_pkg::*;

  ccp_cmd_t cmd;
  logic     in_ready;
  logic     out_valid;
  logic     calibrated;

  ccp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .calibrated (calibrated)
  );

  ccp_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .sample_a         (in_ch.sample_a),
    .sample_b         (in_ch.sample_b),
    .sample_c         (in_ch.sample_c),
    .angle_sample     (in_ch.angle_sample),
    .current_c        (out_ch.current_c),
    .current_alpha    (out_ch.current_alpha),
    .current_beta     (out_ch.current_beta),
    .current_d        (out_ch.current_d),
    .current_q        (out_ch.current_q),
    .electrical_angle (out_ch.electrical_angle)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // No result before the offsets are latched
  a_no_result_uncal: assert property (@(posedge clk) disable iff (!rst_n)
    !calibrated |-> !out_valid)
    else $error("result presented before calibration finished");

  // Calibration, once done, stays done
  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    calibrated |=> calibrated)
    else $error("calibrated flag dropped");

  // A calibrated transaction keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready && calibrated) |=> !in_ready)
    else $error("input reopened while a set is in progress");

endmodule
